// ----- rtl/msd_pkg.sv -----
package msd_pkg;

    localparam int COORD_W    = 16;
    localparam int SUM_W      = 23;
    localparam int DIST_W     = 22;
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_MASK       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE = 8'd1;

    typedef enum logic [1:0] {
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic div_step;
        logic load_direct;
        logic load_quot;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/msd_ctrl.sv -----
module msd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  msd_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output msd_pkg::t_cmd o_cmd
);
    import msd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign take = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC: begin
                if (take && i_sts.last) begin
                    n_state = i_sts.need_div ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_out_valid       = 1'b0;
        o_cmd.div_step    = 1'b0;
        o_cmd.load_quot   = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.load_quot = i_sts.div_done;
            end
            S_OUT: begin
                // next point may start while the result waits, but not finish
                o_in_ready  = !i_sts.last;
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.take        = take;
        o_cmd.load_direct = take && i_sts.last && !i_sts.need_div;
    end

endmodule

// ----- rtl/msd_dp.sv -----
module msd_dp #(
    parameter int MAX_DIMS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  msd_pkg::t_cmd                      i_cmd,
    input  logic signed [msd_pkg::COORD_W-1:0] i_point_value,
    input  logic signed [msd_pkg::COORD_W-1:0] i_medoid_value,
    input  logic                               i_last_dim,
    input  logic [msd_pkg::MASK_W-1:0]         i_dim_mask,
    input  logic                               i_average_enable,
    output msd_pkg::t_sts                      o_sts,
    output logic [msd_pkg::DIST_W-1:0]         o_distance,
    output logic                               o_empty_mask
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIMS + 1);

    // accumulators
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_pos;
    logic [SUM_W-1:0]      n_sum;
    logic [CNT_W-1:0]      n_cnt;
    logic [CNT_W-1:0]      n_pos;

    // divider
    logic [SUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_dvs;
    logic [STEP_W-1:0]     r_step;
    logic [SUM_W-1:0]      n_quo;
    logic [CNT_W-1:0]      n_rem;

    // result
    logic [DIST_W-1:0]     r_dist;
    logic                  r_empty;

    logic [MASK_IDX_W:0]   pos_ext;
    logic                  in_range;
    logic                  sel;
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]    mag;
    logic [CNT_W:0]        rem_sh;
    logic [CNT_W+1:0]      trial;
    logic                  ge;

    assign pos_ext  = (MASK_IDX_W + 1)'(r_pos);
    assign in_range = r_pos < CNT_W'(MAX_DIMS);
    assign sel      = in_range && i_dim_mask[pos_ext[MASK_IDX_W-1:0]];
    assign diff     = {i_point_value[COORD_W-1], i_point_value}
                    - {i_medoid_value[COORD_W-1], i_medoid_value};
    assign mag      = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

    assign n_sum = r_sum + (sel ? SUM_W'(mag) : '0);
    assign n_cnt = r_cnt + CNT_W'(sel);
    assign n_pos = in_range ? r_pos + CNT_W'(1) : r_pos;

    // restoring division, one quotient bit per step
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = !trial[CNT_W+1];
    assign n_rem  = ge ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    assign n_quo  = {r_quo[SUM_W-2:0], ge};

    assign o_sts.last     = i_last_dim;
    assign o_sts.need_div = i_average_enable && (n_cnt != '0);
    assign o_sts.div_done = r_step == STEP_W'(SUM_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_pos <= '0;
        end else if (i_cmd.take) begin
            if (i_last_dim) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_pos <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_last_dim) begin
            r_quo  <= n_sum;
            r_rem  <= '0;
            r_dvs  <= n_cnt;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_dist  <= (n_cnt == '0) ? '0 : n_sum[DIST_W-1:0];
            r_empty <= n_cnt == '0;
        end else if (i_cmd.load_quot) begin
            r_dist  <= n_quo[DIST_W-1:0];
            r_empty <= 1'b0;
        end
    end

    assign o_distance   = r_dist;
    assign o_empty_mask = r_empty;

endmodule

// ----- rtl/masked_l1_segmental_distance.sv -----
// one dimension word per cycle while a point accumulates, but a last word is held while a result waits
// raw-sum mode or empty selection: result registered, valid in the cycle after the last word
// average mode: restoring divider runs after the last word, then valid
// the next point's non-last words are taken while a result waits
// synchronous active-low reset clears accumulators and state and sets config
// (dim_mask all ones, average_enable 1)
module masked_l1_segmental_distance #(
    parameter int MAX_DIMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // point_value[15:0], medoid_value[31:16]
    input  logic        s_axis_tlast,  // last_dim
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // distance[21:0], empty_mask[22], zero[23]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [msd_pkg::MASK_W-1:0]    i_cfg_data
);
    import msd_pkg::*;

    logic [MASK_W-1:0] r_dim_mask;
    logic              r_average_enable;
    t_cmd              cmd;
    t_sts              sts;
    logic [DIST_W-1:0] distance;
    logic              empty_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_mask       <= '1;
            r_average_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIM_MASK:       r_dim_mask       <= i_cfg_data;
                CFG_AVERAGE_ENABLE: r_average_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    msd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    msd_dp #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_point_value    (s_axis_tdata[COORD_W-1:0]),
        .i_medoid_value   (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_last_dim       (s_axis_tlast),
        .i_dim_mask       (r_dim_mask),
        .i_average_enable (r_average_enable),
        .o_sts            (sts),
        .o_distance       (distance),
        .o_empty_mask     (empty_mask)
    );

    assign m_axis_tdata = {1'b0, empty_mask, distance};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21:0] == '0)
        else $error("empty selection with nonzero distance");

    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast
        |=> !(s_axis_tready && s_axis_tlast))
        else $error("second last word taken before result delivered");

    a_pending_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(s_axis_tready && s_axis_tlast))
        else $error("last word taken while result pending");

endmodule
